[hdl/bbw_pkg.sv]
// shared register indexes and constants of the box blur window mean unit
package bbw_pkg;

	localparam int CFG_W = 11;
	localparam int IDX_W = 2;
	localparam int PIX_W = 8;
	localparam int WIN_REG_W = 3;

	localparam logic [IDX_W-1:0] REG_WIDTH = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_WINDOW = 2'd2;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd1024;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd1024;
	localparam logic [WIN_REG_W-1:0] WINDOW_RESET = 3'd3;

	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W = 25;

	// ceil(2^24 / (k*k)) for odd window sides
	function automatic logic [RECIP_W-1:0] recip(input logic [3:0] k);
		logic [RECIP_W-1:0] r;
		unique case (k)
			4'd3: r = 25'd1864136;
			4'd5: r = 25'd671089;
			4'd7: r = 25'd342393;
			4'd9: r = 25'd207127;
			4'd11: r = 25'd138655;
			4'd13: r = 25'd99274;
			4'd15: r = 25'd74566;
			default: r = 25'd16777216;
		endcase
		return r;
	endfunction

endpackage

[hdl/bbw_in_if.sv]
// input pixel channel
interface bbw_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic [7:0] pixel_in;

	modport source(output valid, output operation, output pixel_in, input ready);
	modport sink(input valid, input operation, input pixel_in, output ready);
endinterface

[hdl/bbw_out_if.sv]
// output mean channel
interface bbw_out_if;
	logic valid;
	logic ready;
	logic [7:0] pixel_out;
	logic frame_last;

	modport source(output valid, output pixel_out, output frame_last, input ready);
	modport sink(input valid, input pixel_out, input frame_last, output ready);
endinterface

[hdl/bbw_ram.sv]
// generic single write, single read ram with registered read
module bbw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[hdl/bbw_mean_div.sv]
// window sum divided by window area through a reciprocal multiply
module bbw_mean_div #(
	parameter int SUM_W = 16
) (
	input logic clk,
	input logic load,
	input logic [SUM_W-1:0] sum,
	input logic [3:0] k,
	output logic [7:0] mean
);
	logic [SUM_W+bbw_pkg::RECIP_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= (SUM_W + bbw_pkg::RECIP_W)'(sum) *
				(SUM_W + bbw_pkg::RECIP_W)'(bbw_pkg::recip(k));
		end
	end

	assign mean = prod_q[bbw_pkg::RECIP_SHIFT +: 8];
endmodule

[hdl/box_blur_window_mean_unit.sv]
// top level of the box blur window mean unit
// Streams 8-bit grey pixels in raster order through the "pixels" channel and
// returns the truncated mean of a centred K by K window on the "means" channel.
// Configuration: wr_en, wr_index, wr_data write image width, height and window
// side; writing these restarts the frame. Write only while the block is idle.
// The first p*W+p items of a frame give no output (p = K/2); after the W*H
// pixels the host sends p*W+p flush items. frame_last marks the final output.
// Items are taken one at a time by a sequencer: read of the line-store ram,
// column update and write-back, window sum, reciprocal multiply, output.
// An item without output returns to idle after the column update; an item with
// output runs on through the remaining steps, and its result is registered in
// the output step (plus any wait for the receiver).
// The output register holds a finished result while the next item is taken;
// when the receiver stalls, a further result waits in the last step and no
// new item is taken until the register frees.
// Reset restores the register defaults and clears all counters and handshake
// state; the line-store ram is never cleared, its reads are masked by row.
module box_blur_window_mean_unit #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_WINDOW = 7
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [bbw_pkg::IDX_W-1:0] wr_index,
	input logic [bbw_pkg::CFG_W-1:0] wr_data,
	bbw_in_if.sink pixels,
	bbw_out_if.source means
);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT + MAX_WINDOW + 1);
	localparam int OW = $clog2(MAX_HEIGHT);
	localparam int KW = $clog2(MAX_WINDOW + 1);
	localparam int LINES = MAX_WINDOW - 1;
	localparam int CSW = $clog2(MAX_WINDOW * 255 + 1);
	localparam int SW = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
	localparam int TOPK = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;

	typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_SUM, ST_MUL, ST_OUT} state_t;

	state_t state_q;

	logic [bbw_pkg::CFG_W-1:0] width_q;
	logic [bbw_pkg::CFG_W-1:0] height_q;
	logic [bbw_pkg::WIN_REG_W-1:0] window_q;

	logic [RW-1:0] rin_q;
	logic [CW-1:0] cin_q;
	logic [CW-1:0] ocol_q;
	logic [OW-1:0] orow_q;

	logic [7:0] fresh_s1;
	logic [RW-1:0] rin_s1;
	logic [CW-1:0] cin_s1;
	logic [CW-1:0] ocol_s1;
	logic emit_s1;
	logic last_s1;
	logic [SW-1:0] sum_s2;

	logic [CSW-1:0] hist_q [MAX_WINDOW];

	logic out_valid_q;
	logic [7:0] pixel_out_q;
	logic last_q;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [KW-1:0] k_eff;
	logic [KW-1:0] p_eff;
	logic [bbw_pkg::WIN_REG_W-1:0] k_raw;

	logic acc;
	logic emit;
	logic last;
	logic cin_end;
	logic cfg_hit;
	logic [7:0] fresh;

	logic [LINES*8-1:0] rd_word;
	logic [LINES*8-1:0] wr_word;
	logic [CSW-1:0] colsum;
	logic [SW-1:0] wsum;
	logic [7:0] mean;

	// effective sizes
	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
		if (window_q == '0) begin
			k_raw = 3'd1;
		end else if (!window_q[0]) begin
			k_raw = window_q - 3'd1;
		end else begin
			k_raw = window_q;
		end
		if (32'(k_raw) > TOPK) begin
			k_eff = KW'(TOPK);
		end else begin
			k_eff = KW'(k_raw);
		end
		p_eff = k_eff >> 1;
	end

	assign pixels.ready = (state_q == ST_IDLE);
	assign acc = pixels.valid && pixels.ready;

	// items taken so far in the frame against p*W+p
	assign emit = (32'(rin_q) * 32'(w_eff) + 32'(cin_q)) >=
		(32'(p_eff) * 32'(w_eff) + 32'(p_eff));
	assign last = (32'(orow_q) + 32'd1 >= 32'(h_eff)) &&
		(32'(ocol_q) + 32'd1 >= 32'(w_eff));
	assign cin_end = (32'(cin_q) + 32'd1 >= 32'(w_eff));
	assign fresh = ((32'(rin_q) < 32'(h_eff)) && (pixels.operation == bbw_pkg::OP_PIXEL)) ?
		pixels.pixel_in : 8'd0;
	assign cfg_hit = wr_en && ((wr_index == bbw_pkg::REG_WIDTH) ||
		(wr_index == bbw_pkg::REG_HEIGHT) || (wr_index == bbw_pkg::REG_WINDOW));

	bbw_ram #(
		.WIDTH(LINES * 8),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk(clk),
		.we(state_q == ST_RD),
		.waddr(cin_s1),
		.wdata(wr_word),
		.re(acc),
		.raddr(cin_q),
		.rdata(rd_word)
	);

	// column update: masked line reads, shifted write-back, column sum
	always_comb begin
		colsum = CSW'(fresh_s1);
		wr_word = '0;
		wr_word[7:0] = fresh_s1;
		for (int j = 0; j < LINES; j++) begin
			if ((j + 1 < int'(k_eff)) && (32'(rin_s1) > j)) begin
				colsum = colsum + CSW'(rd_word[j*8 +: 8]);
			end
		end
		for (int j = 1; j < LINES; j++) begin
			if (32'(rin_s1) > j - 1) begin
				wr_word[j*8 +: 8] = rd_word[(j-1)*8 +: 8];
			end
		end
	end

	// window sum over column sums that fall inside the image
	always_comb begin
		wsum = '0;
		for (int j = 0; j < MAX_WINDOW; j++) begin
			if ((j < int'(k_eff)) && (int'(ocol_s1) + int'(p_eff) - j >= 0) &&
				(int'(ocol_s1) + int'(p_eff) - j < int'(w_eff))) begin
				wsum = wsum + SW'(hist_q[j]);
			end
		end
	end

	bbw_mean_div #(
		.SUM_W(SW)
	) u_div (
		.clk(clk),
		.load(state_q == ST_MUL),
		.sum(sum_s2),
		.k(4'(k_eff)),
		.mean(mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			width_q <= bbw_pkg::WIDTH_RESET;
			height_q <= bbw_pkg::HEIGHT_RESET;
			window_q <= bbw_pkg::WINDOW_RESET;
			rin_q <= '0;
			cin_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			out_valid_q <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			if (means.valid && means.ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						fresh_s1 <= fresh;
						rin_s1 <= rin_q;
						cin_s1 <= cin_q;
						ocol_s1 <= ocol_q;
						emit_s1 <= emit;
						last_s1 <= last;
						if (emit && last) begin
							rin_q <= '0;
							cin_q <= '0;
							ocol_q <= '0;
							orow_q <= '0;
						end else begin
							if (cin_end) begin
								cin_q <= '0;
								rin_q <= rin_q + RW'(1);
							end else begin
								cin_q <= cin_q + CW'(1);
							end
							if (emit) begin
								if (32'(ocol_q) + 32'd1 >= 32'(w_eff)) begin
									ocol_q <= '0;
									orow_q <= orow_q + OW'(1);
								end else begin
									ocol_q <= ocol_q + CW'(1);
								end
							end
						end
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					hist_q[0] <= colsum;
					for (int j = 1; j < MAX_WINDOW; j++) begin
						hist_q[j] <= hist_q[j-1];
					end
					state_q <= emit_s1 ? ST_SUM : ST_IDLE;
				end
				ST_SUM: begin
					sum_s2 <= wsum;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || means.ready) begin
						out_valid_q <= 1'b1;
						pixel_out_q <= mean;
						last_q <= last_s1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (wr_en) begin
				unique case (wr_index)
					bbw_pkg::REG_WIDTH: width_q <= wr_data;
					bbw_pkg::REG_HEIGHT: height_q <= wr_data;
					bbw_pkg::REG_WINDOW: window_q <= wr_data[bbw_pkg::WIN_REG_W-1:0];
					default: begin
					end
				endcase
			end
			if (cfg_hit) begin
				rin_q <= '0;
				cin_q <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end
		end
	end

	assign means.valid = out_valid_q;
	assign means.pixel_out = pixel_out_q;
	assign means.frame_last = last_q;

`ifndef ASSERT_OFF
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(pixels.valid && pixels.ready) |=> (state_q == ST_RD))
		else $error("transfer not followed by line read");

	a_out_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> emit_s1)
		else $error("output step without an emitting item");

	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(means.valid) |-> $past(state_q == ST_OUT))
		else $error("result appeared outside the output step");
`endif
endmodule
